[rtl/core/wsp_pkg.sv]
// ----------------------------------------------------------------------------
// wsp_pkg
// shared types, widths and register codes of the world-to-screen projection
// ----------------------------------------------------------------------------
package wsp_pkg;

	localparam int COEFF_WIDTH = 16;
	localparam int POS_WIDTH   = 32;
	localparam int FRAC_POS    = 16;
	localparam int FRAC_CLIP   = 28;
	localparam int REG_W       = 64;
	localparam int SIZE_W      = 14;
	localparam int ADDR_W      = 6;
	localparam int PROD_W      = POS_WIDTH + COEFF_WIDTH;
	localparam int CLIP_W      = PROD_W + 2;
	localparam int Q_W         = CLIP_W + 1;
	localparam int M_W         = SIZE_W + 7;
	localparam int LO_W        = 25;
	localparam int HI_W        = Q_W - LO_W;
	localparam int LO_PW       = LO_W + M_W;
	localparam int HI_PW       = HI_W + M_W + 1;
	localparam int N_W         = Q_W + M_W + 3;
	localparam int OUT_W       = 24;
	localparam int QUO_W       = OUT_W;
	localparam int DIV_STAGES  = QUO_W + 1;
	localparam int BACK_STAGES = DIV_STAGES + 3;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = 2;
	localparam int FIFO_CW     = 3;

	localparam logic signed [CLIP_W-1:0] ONE_CLIP = CLIP_W'(1) <<< FRAC_CLIP;
	localparam logic signed [OUT_W-1:0]  OUT_MAX  = {1'b0, {(OUT_W-1){1'b1}}};
	localparam logic signed [OUT_W-1:0]  OUT_MIN  = {1'b1, {(OUT_W-1){1'b0}}};

	typedef enum logic [2:0] {
		REG_COEF_X = 3'd0,
		REG_COEF_Y = 3'd1,
		REG_COEF_Z = 3'd2,
		REG_COEF_T = 3'd3,
		REG_WIDTH  = 3'd4,
		REG_HEIGHT = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic [REG_W-1:0] coef_x;
		logic [REG_W-1:0] coef_y;
		logic [REG_W-1:0] coef_z;
		logic [REG_W-1:0] coef_t;
	} coef_t;

	typedef struct packed {
		logic signed [CLIP_W-1:0] cx;
		logic signed [CLIP_W-1:0] cy;
		logic signed [CLIP_W-1:0] cw;
	} clip_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	function automatic logic signed [COEFF_WIDTH-1:0] lane(input logic [REG_W-1:0] r,
		input int k);
		return r[k*COEFF_WIDTH +: COEFF_WIDTH];
	endfunction

	// clip x, y and w come from lanes 0, 1 and 3
	function automatic int lane_of(input int i);
		return (i == 2) ? 3 : i;
	endfunction

endpackage

[rtl/core/wsp_front.sv]
// ----------------------------------------------------------------------------
// wsp_front
// accepts points, forms clip x, y and w, clamps w and hands them on
// ----------------------------------------------------------------------------
module wsp_front (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 push,
	output logic                                 full,
	input  logic signed [wsp_pkg::POS_WIDTH-1:0] pos_x,
	input  logic signed [wsp_pkg::POS_WIDTH-1:0] pos_y,
	input  logic signed [wsp_pkg::POS_WIDTH-1:0] pos_z,
	input  wsp_pkg::coef_t                       coef,
	input  logic                                 fifo_full,
	output logic                                 fifo_push,
	output wsp_pkg::clip_t                       fifo_data
);
	import wsp_pkg::*;

	logic                            en;
	logic                            v_s1;
	logic                            v_s2;
	logic signed [PROD_W-1:0]        px_s1 [3];
	logic signed [PROD_W-1:0]        py_s1 [3];
	logic signed [PROD_W-1:0]        pz_s1 [3];
	logic signed [COEFF_WIDTH-1:0]   t_s1  [3];
	logic signed [CLIP_W-1:0]        sum   [3];
	clip_t                           clip_s2;

	assign en        = !(v_s2 && fifo_full);
	assign full      = !en;
	assign fifo_push = v_s2 && !fifo_full;
	assign fifo_data = clip_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s1 <= push;
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < 3; i++) begin
				px_s1[i] <= pos_x * lane(coef.coef_x, lane_of(i));
				py_s1[i] <= pos_y * lane(coef.coef_y, lane_of(i));
				pz_s1[i] <= pos_z * lane(coef.coef_z, lane_of(i));
				t_s1[i]  <= lane(coef.coef_t, lane_of(i));
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			sum[i] = CLIP_W'(px_s1[i]) + CLIP_W'(py_s1[i]) + CLIP_W'(pz_s1[i])
				+ (CLIP_W'(t_s1[i]) <<< FRAC_POS);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			clip_s2.cx <= sum[0];
			clip_s2.cy <= sum[1];
			clip_s2.cw <= (sum[2] < ONE_CLIP) ? ONE_CLIP : sum[2];
		end
	end

endmodule

[rtl/core/wsp_fifo.sv]
// ----------------------------------------------------------------------------
// wsp_fifo
// short queue of clip beats between front and back
// ----------------------------------------------------------------------------
module wsp_fifo (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wsp_pkg::clip_t       wdata,
	input  logic                 pop,
	output wsp_pkg::clip_t       rdata,
	output wsp_pkg::fifo_stat_t  stat
);
	import wsp_pkg::*;

	clip_t                mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]   wr_ptr_q;
	logic [FIFO_AW-1:0]   rd_ptr_q;
	logic [FIFO_CW-1:0]   cnt_q;

	assign stat.full  = (cnt_q == FIFO_CW'(FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rdata      = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

endmodule

[rtl/core/wsp_div.sv]
// ----------------------------------------------------------------------------
// wsp_div
// pipelined restoring divider, one quotient bit per stage after the input stage, saturating
// ----------------------------------------------------------------------------
module wsp_div (
	input  logic                               clk,
	input  logic                               en,
	input  logic signed [wsp_pkg::N_W-1:0]     num,
	input  logic signed [wsp_pkg::CLIP_W-1:0]  den,
	output logic signed [wsp_pkg::OUT_W-1:0]   res
);
	import wsp_pkg::*;

	// numerator carries a bias of 2^23 times den
	logic signed [N_W-1:0]     rem_s [DIV_STAGES];
	logic signed [CLIP_W-1:0]  den_s [DIV_STAGES];
	logic [QUO_W-1:0]          quo_s [DIV_STAGES];
	logic                      neg_s [DIV_STAGES];
	logic                      ovf_s [DIV_STAGES];

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num;
			den_s[0] <= den;
			quo_s[0] <= '0;
			neg_s[0] <= num[N_W-1];
			ovf_s[0] <= num >= (N_W'(den) <<< QUO_W);
		end
	end

	for (genvar j = 1; j < DIV_STAGES; j++) begin : g_stage
		logic signed [N_W-1:0] cand;
		assign cand = rem_s[j-1] - (N_W'(den_s[j-1]) <<< (QUO_W - j));
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j] <= den_s[j-1];
				neg_s[j] <= neg_s[j-1];
				ovf_s[j] <= ovf_s[j-1];
				if (!cand[N_W-1]) begin
					rem_s[j] <= cand;
					quo_s[j] <= quo_s[j-1] | (QUO_W'(1) << (QUO_W - j));
				end else begin
					rem_s[j] <= rem_s[j-1];
					quo_s[j] <= quo_s[j-1];
				end
			end
		end
	end

	always_comb begin
		if (neg_s[DIV_STAGES-1]) begin
			res = OUT_MIN;
		end else if (ovf_s[DIV_STAGES-1]) begin
			res = OUT_MAX;
		end else begin
			res = {~quo_s[DIV_STAGES-1][QUO_W-1], quo_s[DIV_STAGES-1][QUO_W-2:0]};
		end
	end

endmodule

[rtl/core/wsp_back.sv]
// ----------------------------------------------------------------------------
// wsp_back
// viewport mapping: scales by screen size and divides by w per axis
// ----------------------------------------------------------------------------
module wsp_back (
	input  logic                                clk,
	input  logic                                arst_n,
	input  wsp_pkg::clip_t                      fifo_data,
	input  wsp_pkg::fifo_stat_t                 fifo_stat,
	output logic                                fifo_pop,
	input  logic [wsp_pkg::M_W-1:0]             m_x,
	input  logic [wsp_pkg::M_W-1:0]             m_y,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [wsp_pkg::OUT_W-1:0]    screen_x,
	output logic signed [wsp_pkg::OUT_W-1:0]    screen_y
);
	import wsp_pkg::*;

	logic                      en;
	logic [BACK_STAGES-1:0]    v_q;
	logic signed [Q_W-1:0]     qx_s1;
	logic signed [Q_W-1:0]     qy_s1;
	logic signed [CLIP_W-1:0]  w_s1;
	logic [LO_PW-1:0]          lox_s2;
	logic [LO_PW-1:0]          loy_s2;
	logic signed [HI_PW-1:0]   hix_s2;
	logic signed [HI_PW-1:0]   hiy_s2;
	logic signed [CLIP_W-1:0]  w_s2;
	logic signed [N_W-1:0]     nx_s3;
	logic signed [N_W-1:0]     ny_s3;
	logic signed [CLIP_W-1:0]  w_s3;

	assign empty    = !v_q[BACK_STAGES-1];
	assign en       = empty || pop;
	assign fifo_pop = en && !fifo_stat.empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[BACK_STAGES-2:0], fifo_pop};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			qx_s1  <= Q_W'(fifo_data.cx) + Q_W'(fifo_data.cw);
			qy_s1  <= Q_W'(fifo_data.cw) - Q_W'(fifo_data.cy);
			w_s1   <= fifo_data.cw;
			lox_s2 <= qx_s1[LO_W-1:0] * m_x;
			loy_s2 <= qy_s1[LO_W-1:0] * m_y;
			hix_s2 <= $signed(qx_s1[Q_W-1:LO_W]) * $signed({1'b0, m_x});
			hiy_s2 <= $signed(qy_s1[Q_W-1:LO_W]) * $signed({1'b0, m_y});
			w_s2   <= w_s1;
			nx_s3  <= (N_W'(hix_s2) <<< LO_W) + N_W'($signed({1'b0, lox_s2}))
				+ (N_W'(w_s2) <<< (QUO_W - 1));
			ny_s3  <= (N_W'(hiy_s2) <<< LO_W) + N_W'($signed({1'b0, loy_s2}))
				+ (N_W'(w_s2) <<< (QUO_W - 1));
			w_s3   <= w_s2;
		end
	end

	wsp_div u_div_x (
		.clk (clk),
		.en  (en),
		.num (nx_s3),
		.den (w_s3),
		.res (screen_x)
	);

	wsp_div u_div_y (
		.clk (clk),
		.en  (en),
		.num (ny_s3),
		.den (w_s3),
		.res (screen_y)
	);

endmodule

[rtl/core/world_to_screen_projection_unit.sv]
// ----------------------------------------------------------------------------
// world_to_screen_projection_unit
// projects a world point through a 4x4 matrix onto viewport pixels
// ----------------------------------------------------------------------------
// Input channel: push/full with pos_x, pos_y, pos_z in signed Q16.16. A beat
// goes in at an edge with push high and full low.
// Result channel: empty/pop with screen_x, screen_y in signed Q16.8 pixels,
// saturated. The oldest result shows while empty is low and leaves at an edge
// with pop high.
// Registers: APB writes at byte address 8*i, 64-bit data, pready tied high.
// Throughput: one point per cycle while full is low. From accept to result,
// the accept edge loads the first of two matrix stages, then the clip queue,
// three scaling stages and a 25-stage divider per axis whose stages after
// the first each form one quotient bit.
// A stalled result holds the back pipeline; the front keeps accepting until
// the four-entry clip queue is full and a beat waits for it; then full rises.
// Reset clears all valid state and loads the identity matrix and a 1920x1080
// viewport; no clearing pass is needed.
// ----------------------------------------------------------------------------
module world_to_screen_projection_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [wsp_pkg::ADDR_W-1:0]          paddr,
	input  logic [wsp_pkg::REG_W-1:0]           pwdata,
	output logic [wsp_pkg::REG_W-1:0]           prdata,
	output logic                                pready,
	input  logic                                push,
	output logic                                full,
	input  logic signed [wsp_pkg::POS_WIDTH-1:0] pos_x,
	input  logic signed [wsp_pkg::POS_WIDTH-1:0] pos_y,
	input  logic signed [wsp_pkg::POS_WIDTH-1:0] pos_z,
	output logic                                empty,
	input  logic                                pop,
	output logic signed [wsp_pkg::OUT_W-1:0]    screen_x,
	output logic signed [wsp_pkg::OUT_W-1:0]    screen_y
);
	import wsp_pkg::*;

	coef_t               coef_q;
	logic [SIZE_W-1:0]   width_q;
	logic [SIZE_W-1:0]   height_q;
	logic                wr_en;
	reg_idx_t            idx;
	logic                f_push;
	logic                f_pop;
	clip_t               f_wdata;
	clip_t               f_rdata;
	fifo_stat_t          f_stat;
	logic [M_W-1:0]      m_x;
	logic [M_W-1:0]      m_y;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;
	assign idx    = reg_idx_t'(paddr[ADDR_W-1:3]);
	assign m_x    = {width_q, 7'b0};
	assign m_y    = {height_q, 7'b0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			coef_q.coef_x <= REG_W'(1) << 12;
			coef_q.coef_y <= REG_W'(1) << 28;
			coef_q.coef_z <= REG_W'(1) << 44;
			coef_q.coef_t <= REG_W'(1) << 60;
			width_q       <= SIZE_W'(1920);
			height_q      <= SIZE_W'(1080);
		end else if (wr_en) begin
			case (idx)
				REG_COEF_X: coef_q.coef_x <= pwdata;
				REG_COEF_Y: coef_q.coef_y <= pwdata;
				REG_COEF_Z: coef_q.coef_z <= pwdata;
				REG_COEF_T: coef_q.coef_t <= pwdata;
				REG_WIDTH:  width_q       <= pwdata[SIZE_W-1:0];
				REG_HEIGHT: height_q      <= pwdata[SIZE_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_COEF_X: prdata = coef_q.coef_x;
			REG_COEF_Y: prdata = coef_q.coef_y;
			REG_COEF_Z: prdata = coef_q.coef_z;
			REG_COEF_T: prdata = coef_q.coef_t;
			REG_WIDTH:  prdata = REG_W'(width_q);
			REG_HEIGHT: prdata = REG_W'(height_q);
			default:    prdata = '0;
		endcase
	end

	wsp_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.full      (full),
		.pos_x     (pos_x),
		.pos_y     (pos_y),
		.pos_z     (pos_z),
		.coef      (coef_q),
		.fifo_full (f_stat.full),
		.fifo_push (f_push),
		.fifo_data (f_wdata)
	);

	wsp_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (f_push),
		.wdata  (f_wdata),
		.pop    (f_pop),
		.rdata  (f_rdata),
		.stat   (f_stat)
	);

	wsp_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.fifo_data (f_rdata),
		.fifo_stat (f_stat),
		.fifo_pop  (f_pop),
		.m_x       (m_x),
		.m_y       (m_y),
		.empty     (empty),
		.pop       (pop),
		.screen_x  (screen_x),
		.screen_y  (screen_y)
	);

`ifndef NO_ASSERTIONS
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_push && f_stat.full))
		else $error("clip queue written while full");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_pop && f_stat.empty))
		else $error("clip queue read while empty");
	a_stat_sane: assert property (@(posedge clk) disable iff (!arst_n)
		!(f_stat.full && f_stat.empty))
		else $error("clip queue both full and empty");
	a_full_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		full |-> f_stat.full)
		else $error("input blocked without a full clip queue");
`endif

endmodule
